// ----- sv/rgbhsv_pkg.sv -----
// Package for the RGB to HSV converter: item types and sector codes.
// No dependencies.
package rgbhsv_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue_chan;
  } in_item_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
  } out_item_t;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2,
    SECT_GREY  = 2'd3
  } sector_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    sector_t    sector;
    logic       neg;
    logic [7:0] diff_mag;
    logic [7:0] delta;
    logic [7:0] hi;
  } class_t;

endpackage

// ----- sv/rgbhsv_front.sv -----
// Front part of the RGB to HSV converter: max, min, sector and difference.
// Depends on rgbhsv_pkg.
module rgbhsv_front (
  input  rgbhsv_pkg::in_item_t pix,
  output rgbhsv_pkg::class_t   cls
);

  logic [7:0] r, g, b, hi, lo;
  logic signed [8:0] diff;

  always_comb begin
    r = pix.red;
    g = pix.green;
    b = pix.blue_chan;
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    cls.hi = hi;
    cls.delta = hi - lo;
    priority if (hi == lo) begin
      cls.sector = rgbhsv_pkg::SECT_GREY;
      diff = '0;
    end else if (hi == r) begin
      cls.sector = rgbhsv_pkg::SECT_RED;
      diff = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (hi == g) begin
      cls.sector = rgbhsv_pkg::SECT_GREEN;
      diff = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      cls.sector = rgbhsv_pkg::SECT_BLUE;
      diff = $signed({1'b0, r}) - $signed({1'b0, g});
    end
    cls.neg = diff[8];
    cls.diff_mag = diff[8] ? 8'(-diff) : diff[7:0];
  end

endmodule

// ----- sv/rgbhsv_divpipe.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Carries a side payload along. No package dependency.
module rgbhsv_divpipe #(
  parameter int NUM_W = 8,
  parameter int DEN_W = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_v,
  output logic [NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  logic                v_r   [NUM_W+1];
  logic [DEN_W:0]      rem_r [NUM_W+1];
  logic [NUM_W-1:0]    n_r   [NUM_W+1];
  logic [NUM_W-1:0]    q_r   [NUM_W+1];
  logic [DEN_W-1:0]    d_r   [NUM_W+1];
  logic [SIDE_W-1:0]   s_r   [NUM_W+1];

  always_comb begin
    v_r[0] = in_v;
    rem_r[0] = '0;
    n_r[0] = num;
    q_r[0] = '0;
    d_r[0] = den;
    s_r[0] = side;
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W+1:0] trial;
    logic [DEN_W+1:0] sub;
    assign trial = {rem_r[k], n_r[k][NUM_W-1-k]};
    assign sub = trial - {2'b00, d_r[k]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
      if (en) begin
        n_r[k+1] <= n_r[k];
        d_r[k+1] <= d_r[k];
        s_r[k+1] <= s_r[k];
        if (!sub[DEN_W+1]) begin
          rem_r[k+1] <= sub[DEN_W:0];
          q_r[k+1] <= q_r[k] | (NUM_W'(1) << (NUM_W-1-k));
        end else begin
          rem_r[k+1] <= trial[DEN_W:0];
          q_r[k+1] <= q_r[k];
        end
      end
    end
  end

  assign out_v = v_r[NUM_W];
  assign quo = q_r[NUM_W];
  assign side_out = s_r[NUM_W];

endmodule

// ----- sv/rgbhsv_back.sv -----
// Back part of the RGB to HSV converter: hue and saturation division pipelines.
// Depends on rgbhsv_pkg and rgbhsv_divpipe.
module rgbhsv_back #(
  parameter int HUE_FRAC_BITS = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_v,
  input  rgbhsv_pkg::class_t      cls,
  output logic                    out_v,
  output rgbhsv_pkg::out_item_t   res
);

  localparam int SCALE = 1 << HUE_FRAC_BITS;
  localparam int NUM_W = $clog2(360 * SCALE * 255 + 1);

  logic [NUM_W-1:0] hnum, snum;
  logic [NUM_W:0]   base, dterm, full;
  logic [NUM_W-1:0] hq, sq;
  logic [7:0]       side_h;
  logic             hv, sv;

  always_comb begin
    dterm = (NUM_W+1)'(60 * SCALE) * (NUM_W+1)'(cls.diff_mag);
    unique case (cls.sector)
      rgbhsv_pkg::SECT_RED:   base = cls.neg ? (NUM_W+1)'(360 * SCALE) * (NUM_W+1)'(cls.delta)
                                             : '0;
      rgbhsv_pkg::SECT_GREEN: base = (NUM_W+1)'(120 * SCALE) * (NUM_W+1)'(cls.delta);
      rgbhsv_pkg::SECT_BLUE:  base = (NUM_W+1)'(240 * SCALE) * (NUM_W+1)'(cls.delta);
      default:                base = '0;
    endcase
    full = cls.neg ? base - dterm : base + dterm;
    hnum = (cls.sector == rgbhsv_pkg::SECT_GREY) ? '0 : full[NUM_W-1:0];
    snum = NUM_W'(255) * NUM_W'(cls.delta);
  end

  rgbhsv_divpipe #(.NUM_W(NUM_W), .DEN_W(8), .SIDE_W(8)) u_hdiv (
    .clk, .rst_n, .en, .in_v, .num(hnum),
    .den((cls.delta == 8'd0) ? 8'd1 : cls.delta), .side(cls.hi),
    .out_v(hv), .quo(hq), .side_out(side_h)
  );

  rgbhsv_divpipe #(.NUM_W(NUM_W), .DEN_W(8), .SIDE_W(1)) u_sdiv (
    .clk, .rst_n, .en, .in_v, .num(snum),
    .den((cls.hi == 8'd0) ? 8'd1 : cls.hi), .side(1'b0),
    .out_v(sv), .quo(sq), .side_out()
  );

  assign out_v = hv & sv;
  assign res.hue = hq[14:0];
  assign res.saturation = sq[7:0];
  assign res.brightness = side_h;

endmodule

// ----- sv/rgb_to_hsv_pixel_converter.sv -----
// Top level of the RGB to HSV converter: front, queue register, back, output.
// Depends on rgbhsv_pkg, rgbhsv_front and rgbhsv_back.
//
//  channel | direction | ports
//  input   | in        | in_valid, in_stall, in_data
//  result  | out       | out_valid, out_stall, out_data
//
// One item per clock sustained while the result side does not stall; an accepted item passes
// through the queue register, the divider stages (one per quotient bit) and the output
// register before it shows on out_valid. Reset clears all valid flags. A stall on the
// result side freezes the back pipeline; the front register still takes one item.
module rgb_to_hsv_pixel_converter #(
  parameter int HUE_FRAC_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rgbhsv_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rgbhsv_pkg::out_item_t out_data
);

  rgbhsv_pkg::class_t    cls, q_r;
  rgbhsv_pkg::out_item_t res;
  logic q_v_r, bv, en, out_v_r;
  rgbhsv_pkg::out_item_t out_r;

  rgbhsv_front u_front (.pix(in_data), .cls(cls));

  assign en = !out_v_r || !out_stall;
  assign in_stall = q_v_r && !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
    end else if (!in_stall) begin
      q_v_r <= in_valid;
    end
    if (!in_stall) begin
      q_r <= cls;
    end
  end

  rgbhsv_back #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_back (
    .clk, .rst_n, .en, .in_v(q_v_r), .cls(q_r), .out_v(bv), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= bv;
    end
    if (en) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data = out_r;

endmodule

// ----- sv/rgbhsv_checker.sv -----
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Depends on rgbhsv_pkg.
module rgbhsv_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input rgbhsv_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result item changed.");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hue < 15'd23040)
    else $error("Hue out of range.");

  a_sat_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.brightness == 8'd0 |-> out_data.saturation == 8'd0)
    else $error("Black item with nonzero saturation.");

  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("Input stalled with empty output.");

endmodule

bind rgb_to_hsv_pixel_converter rgbhsv_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_data
);

// ----- sim/tb_top.sv -----
// Testbench for the RGB to HSV pixel converter: directed and random pixels,
// each result checked against an integer HSV computation. Depends on rgbhsv_pkg and rgb_to_hsv_pixel_converter.
`timescale 1ns / 100ps
module tb_top;

  localparam int HUE_FRAC_BITS = 6;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  rgbhsv_pkg::in_item_t  in_data;
  logic                  out_valid;
  logic                  out_stall;
  rgbhsv_pkg::out_item_t out_data;

  rgbhsv_pkg::out_item_t hsv_expected[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_recv = 0;

  rgb_to_hsv_pixel_converter #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  function automatic rgbhsv_pkg::out_item_t convert_pixel(rgbhsv_pkg::in_item_t px);
    rgbhsv_pkg::out_item_t res;
    int r, g, b, hi, lo, delta, diff, offset;
    longint num, scale;
    r = px.red;
    g = px.green;
    b = px.blue_chan;
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    delta = hi - lo;
    scale = longint'(1) << HUE_FRAC_BITS;
    res = '0;
    res.brightness = hi[7:0];
    if (hi != 0) res.saturation = 8'((255 * delta) / hi);
    if (delta != 0) begin
      if (hi == r) begin
        diff = g - b;
        offset = 0;
      end else if (hi == g) begin
        diff = b - r;
        offset = 120;
      end else begin
        diff = r - g;
        offset = 240;
      end
      num = 60 * longint'(diff) * scale + longint'(offset) * scale * delta;
      if (num < 0) num += 360 * scale * delta;
      res.hue = 15'(num / delta);
    end
    return res;
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    rgbhsv_pkg::in_item_t px;
    px.red = r;
    px.green = g;
    px.blue_chan = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    hsv_expected.push_back(convert_pixel(px));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (hsv_expected.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n || hold_recv) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    rgbhsv_pkg::out_item_t exp_hsv;
    if (rst_n && out_valid && !out_stall) begin
      if (hsv_expected.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, out_data);
        errors++;
      end else begin
        exp_hsv = hsv_expected.pop_front();
        if (out_data.hue !== exp_hsv.hue) begin
          $display("%0t hue: expected %0d actual %0d", $time, exp_hsv.hue, out_data.hue);
          errors++;
        end
        if (out_data.saturation !== exp_hsv.saturation) begin
          $display("%0t saturation: expected %0d actual %0d", $time,
                   exp_hsv.saturation, out_data.saturation);
          errors++;
        end
        if (out_data.brightness !== exp_hsv.brightness) begin
          $display("%0t brightness: expected %0d actual %0d", $time,
                   exp_hsv.brightness, out_data.brightness);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd200, 8'd200, 8'd10);
    send_pixel(8'd10, 8'd200, 8'd200);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd253);
    send_pixel(8'd3, 8'd1, 8'd2);
    send_pixel(8'd2, 8'd3, 8'd1);
    send_pixel(8'd1, 8'd2, 8'd3);
    send_pixel(8'd170, 8'd85, 8'd255);
    send_pixel(8'd255, 8'd1, 8'd254);
    wait_drained();
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    logic [7:0] r, g, b;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      case ($urandom_range(5))
        0: g = r;
        1: b = r;
        2: begin
          g = r;
          b = r;
        end
        default: ;
      endcase
      send_pixel(r, g, b);
    end
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1;
        repeat (200) @(posedge clk);
        hold_recv = 0;
      end
      repeat (40) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    join
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(120, 0, 0);
    test_random(80, 82, 0);
    test_random(80, 0, 82);
    test_random(100, 12, 12);
    test_backpressure();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
